// ===== hdl/tcc_pkg.sv =====
// shared types and constants of the text console controller
package tcc_pkg;

	localparam int CELL_W = 16;
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

	localparam logic [7:0] CHR_PRINT_LO  = 8'd32;
	localparam logic [7:0] CHR_PRINT_HI  = 8'd126;
	localparam logic [7:0] CHR_BACKSPACE = 8'd8;
	localparam logic [7:0] CHR_TAB       = 8'd9;
	localparam logic [7:0] CHR_LINE_FEED = 8'd10;
	localparam logic [7:0] CHR_FORM_FEED = 8'd12;
	localparam logic [7:0] CHR_RETURN    = 8'd13;

	localparam int TAB_STOP   = 8;
	localparam int FIFO_DEPTH = 2;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_BACKGROUND = 1'b0;
	localparam logic REG_FOREGROUND = 1'b1;
	localparam logic [2:0] BACKGROUND_RESET = 3'd0;
	localparam logic [3:0] FOREGROUND_RESET = 4'd15;

	typedef struct packed {
		logic       cmd;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_column;
	} tcc_in_t;

	typedef struct packed {
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_column;
		logic [10:0] cursor_position;
		logic [15:0] cell_data;
	} tcc_out_t;

	typedef enum logic [3:0] {
		OP_PRINT,
		OP_BACKSPACE,
		OP_TAB,
		OP_LINE_FEED,
		OP_FORM_FEED,
		OP_RETURN,
		OP_IGNORE,
		OP_READ,
		OP_READ_OUT
	} tcc_op_t;

	typedef struct packed {
		tcc_op_t           op;
		logic [CELL_W-1:0] cell_word;
		logic [4:0]        read_row;
		logic [6:0]        read_column;
	} tcc_cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_BLANK
	} tcc_state_t;

endpackage

// ===== hdl/tcc_ram.sv =====
// generic simple dual-port ram with registered read
module tcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/tcc_fifo.sv =====
// short command queue between front and back
module tcc_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  tcc_pkg::tcc_cmd_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output tcc_pkg::tcc_cmd_t pop_data
);
	import tcc_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

	tcc_cmd_t         entry_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

endmodule

// ===== hdl/tcc_front.sv =====
// front end: accepts items and classifies them into commands
module tcc_front #(
	parameter int ROWS    = 25,
	parameter int COLUMNS = 80
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tcc_pkg::tcc_in_t  in_data,
	input  logic [2:0]        background_colour,
	input  logic [3:0]        foreground_colour,
	input  logic              init_busy,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output tcc_pkg::tcc_cmd_t cmd_data
);
	import tcc_pkg::*;

	logic     cmd_valid_s1;
	tcc_cmd_t cmd_s1;
	tcc_cmd_t cls;

	assign in_ready  = !init_busy && (!cmd_valid_s1 || cmd_ready);
	assign cmd_valid = cmd_valid_s1;
	assign cmd_data  = cmd_s1;

	always_comb begin
		cls.cell_word   = {1'b0, background_colour, foreground_colour, in_data.char_code};
		cls.read_row    = in_data.read_row;
		cls.read_column = in_data.read_column;
		if (in_data.cmd) begin
			if (32'(in_data.read_row) < 32'(ROWS) && 32'(in_data.read_column) < 32'(COLUMNS)) begin
				cls.op = OP_READ;
			end else begin
				cls.op = OP_READ_OUT;
			end
		end else if (in_data.char_code >= CHR_PRINT_LO && in_data.char_code <= CHR_PRINT_HI) begin
			cls.op = OP_PRINT;
		end else begin
			unique case (in_data.char_code)
				CHR_BACKSPACE: cls.op = OP_BACKSPACE;
				CHR_TAB:       cls.op = OP_TAB;
				CHR_LINE_FEED: cls.op = OP_LINE_FEED;
				CHR_FORM_FEED: cls.op = OP_FORM_FEED;
				CHR_RETURN:    cls.op = OP_RETURN;
				default:       cls.op = OP_IGNORE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (!cmd_valid_s1 || cmd_ready) begin
			cmd_valid_s1 <= in_valid && !init_busy;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cls;
		end
	end

endmodule

// ===== hdl/tcc_back.sv =====
// back end: cursor, screen store sequencing and result register
module tcc_back #(
	parameter int ROWS    = 25,
	parameter int COLUMNS = 80
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cmd_valid,
	output logic                                        cmd_ready,
	input  tcc_pkg::tcc_cmd_t                           cmd_data,
	output logic                                        init_busy,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output tcc_pkg::tcc_out_t                           out_data,
	output logic                                        ram_we,
	output logic [$clog2(ROWS)+$clog2(COLUMNS)-1:0]     ram_waddr,
	output logic [tcc_pkg::CELL_W-1:0]                  ram_wdata,
	output logic [$clog2(ROWS)+$clog2(COLUMNS)-1:0]     ram_raddr,
	input  logic [tcc_pkg::CELL_W-1:0]                  ram_rdata
);
	import tcc_pkg::*;

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLUMNS);
	localparam int PW = RW + CW;
	localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
	localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);

	tcc_state_t        state_q, state_d;
	logic [RW-1:0]     row_q, row_d;
	logic [RW-1:0]     base_q, base_d;
	logic [RW-1:0]     sweep_row_q, sweep_row_d;
	logic [CW-1:0]     col_q, col_d;
	logic [CW-1:0]     sweep_col_q, sweep_col_d;
	logic              init_q, init_d;
	logic              res_valid_q;
	tcc_out_t          res_q;
	logic              res_free;
	logic              load;
	logic              scroll;
	logic [CELL_W-1:0] res_cell;
	logic [PW-1:0]     pos_full;

	// logical row to physical row of the rotating store
	function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lr, input logic [RW-1:0] b);
		logic [RW:0] sum;
		sum = {1'b0, lr} + {1'b0, b};
		if (sum >= (RW+1)'(ROWS)) begin
			sum = sum - (RW+1)'(ROWS);
		end
		return sum[RW-1:0];
	endfunction

	assign init_busy = init_q;
	assign out_valid = res_valid_q;
	assign out_data  = res_q;
	assign res_free  = !res_valid_q || out_ready;
	assign pos_full  = PW'(row_d) * PW'(COLUMNS) + PW'(col_d);

	always_comb begin
		state_d     = state_q;
		row_d       = row_q;
		col_d       = col_q;
		base_d      = base_q;
		sweep_row_d = sweep_row_q;
		sweep_col_d = sweep_col_q;
		init_d      = init_q;
		load        = 1'b0;
		scroll      = 1'b0;
		res_cell    = '0;
		cmd_ready   = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = {sweep_row_q, sweep_col_q};
		ram_wdata   = BLANK_CELL;
		ram_raddr   = {phys_row(RW'(cmd_data.read_row), base_q), CW'(cmd_data.read_column)};
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (sweep_col_q == LAST_COL) begin
					sweep_col_d = '0;
					if (sweep_row_q == LAST_ROW) begin
						sweep_row_d = '0;
						init_d      = 1'b0;
						state_d     = ST_IDLE;
					end else begin
						sweep_row_d = sweep_row_q + 1'b1;
					end
				end else begin
					sweep_col_d = sweep_col_q + 1'b1;
				end
			end
			ST_BLANK: begin
				ram_we = 1'b1;
				if (sweep_col_q == LAST_COL) begin
					sweep_col_d = '0;
					state_d     = ST_IDLE;
				end else begin
					sweep_col_d = sweep_col_q + 1'b1;
				end
			end
			ST_READ: begin
				load     = 1'b1;
				res_cell = ram_rdata;
				state_d  = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd_valid && res_free) begin
					cmd_ready = 1'b1;
					load      = (cmd_data.op != OP_READ);
					unique case (cmd_data.op)
						OP_PRINT: begin
							ram_we    = 1'b1;
							ram_waddr = {phys_row(row_q, base_q), col_q};
							ram_wdata = cmd_data.cell_word;
							if (col_q == LAST_COL) begin
								col_d = '0;
								if (row_q == LAST_ROW) begin
									scroll = 1'b1;
								end else begin
									row_d = row_q + 1'b1;
								end
							end else begin
								col_d = col_q + 1'b1;
							end
						end
						OP_BACKSPACE: begin
							if (col_q != '0) begin
								col_d = col_q - 1'b1;
							end
						end
						OP_TAB: begin
							if ({1'b0, col_q} + (CW+1)'(TAB_STOP) < (CW+1)'(COLUMNS)) begin
								col_d = (col_q | CW'(TAB_STOP - 1)) + 1'b1;
							end else begin
								col_d = LAST_COL;
							end
						end
						OP_LINE_FEED: begin
							col_d = '0;
							if (row_q == LAST_ROW) begin
								scroll = 1'b1;
							end else begin
								row_d = row_q + 1'b1;
							end
						end
						OP_FORM_FEED: begin
							row_d       = '0;
							col_d       = '0;
							base_d      = '0;
							sweep_row_d = '0;
							sweep_col_d = '0;
							state_d     = ST_CLEAR;
						end
						OP_RETURN: begin
							col_d = '0;
						end
						OP_READ: begin
							state_d = ST_READ;
						end
						OP_READ_OUT, OP_IGNORE: begin
						end
						default: begin
						end
					endcase
					if (scroll) begin
						// old top row becomes the new bottom row
						base_d      = (base_q == LAST_ROW) ? '0 : base_q + 1'b1;
						sweep_row_d = base_q;
						sweep_col_d = '0;
						state_d     = ST_BLANK;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			row_q       <= '0;
			col_q       <= '0;
			base_q      <= '0;
			sweep_row_q <= '0;
			sweep_col_q <= '0;
			init_q      <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			row_q       <= row_d;
			col_q       <= col_d;
			base_q      <= base_d;
			sweep_row_q <= sweep_row_d;
			sweep_col_q <= sweep_col_d;
			init_q      <= init_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.cursor_row      <= 5'(row_d);
			res_q.cursor_column   <= 7'(col_d);
			res_q.cursor_position <= 11'(pos_full);
			res_q.cell_data       <= res_cell;
		end
	end

endmodule

// ===== hdl/text_console_controller_unit.sv =====
// Text console controller top level: ROWS x COLUMNS cell store with cursor
// and an APB-style colour register port. Items pass a one-stage front end
// and a two-entry command queue, then the back end executes them one at a
// time. A printable byte or cursor control finishes in the idle state, so
// results can follow every cycle while results are taken and no memory
// pass runs; a cell read passes a further read state because of the
// registered read of the cell memory. A scroll (line feed on the last row
// or a wrap past the last cell) rotates the row base and blanks one row
// through the single memory write port. A form feed rewrites every cell.
// After reset the same clearing pass runs with in_ready low; register
// writes are taken throughout. The result for a scroll or clear is offered
// as soon as the cursor is known; following items wait in the queue until
// the memory pass ends.
module text_console_controller_unit #(
	parameter int ROWS    = 25,
	parameter int COLUMNS = 80
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tcc_pkg::APB_AW-1:0]   paddr,
	input  logic [tcc_pkg::APB_DW-1:0]   pwdata,
	output logic [tcc_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  tcc_pkg::tcc_in_t             in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output tcc_pkg::tcc_out_t            out_data
);
	import tcc_pkg::*;

	localparam int AW = $clog2(ROWS) + $clog2(COLUMNS);
	localparam int DEPTH = ROWS << $clog2(COLUMNS);

	logic [2:0]        background_q;
	logic [3:0]        foreground_q;
	logic              init_busy;
	logic              fr_valid;
	logic              fr_ready;
	tcc_cmd_t          fr_data;
	logic              bk_valid;
	logic              bk_ready;
	tcc_cmd_t          bk_data;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			background_q <= BACKGROUND_RESET;
			foreground_q <= FOREGROUND_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_BACKGROUND: background_q <= pwdata[2:0];
				REG_FOREGROUND: foreground_q <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BACKGROUND: prdata = APB_DW'(background_q);
			REG_FOREGROUND: prdata = APB_DW'(foreground_q);
			default:        prdata = '0;
		endcase
	end

	tcc_front #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.in_data           (in_data),
		.background_colour (background_q),
		.foreground_colour (foreground_q),
		.init_busy         (init_busy),
		.cmd_valid         (fr_valid),
		.cmd_ready         (fr_ready),
		.cmd_data          (fr_data)
	);

	tcc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_data),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_data   (bk_data)
	);

	tcc_back #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (bk_valid),
		.cmd_ready (bk_ready),
		.cmd_data  (bk_data),
		.init_busy (init_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	tcc_ram #(
		.WIDTH (CELL_W),
		.DEPTH (DEPTH)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ===== hdl/tcc_checker.sv =====
// port-level assertions for the text console controller and their bind
module tcc_checker #(
	parameter int ROWS    = 25,
	parameter int COLUMNS = 80
) (
	input logic              clk,
	input logic              arst_n,
	input logic              pready,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input tcc_pkg::tcc_out_t out_data
);
	import tcc_pkg::*;

	// a stalled result transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// linear position matches row and column
	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ROWS > 32) || (out_data.cursor_position ==
			11'(32'(out_data.cursor_row) * COLUMNS + 32'(out_data.cursor_column))))
		else $error("cursor position mismatch");

	// cursor column stays on screen and cells never carry the blink bit
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_data.cursor_column) < COLUMNS && !out_data.cell_data[15])
		else $error("cursor off screen or blink bit set");

	// input is blocked and the register port ready just after reset is released
	a_init_block: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !in_ready && pready)
		else $error("input taken during reset clear");

endmodule

bind text_console_controller_unit tcc_checker #(
	.ROWS    (ROWS),
	.COLUMNS (COLUMNS)
) u_tcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
